@@ sv/bfbp_pkg.sv @@
// Shared types and constants for the best-fit bin packer.
`default_nettype none
package bfbp_pkg;

  localparam int MAX_BINS_DEF = 64;
  localparam int SIZE_W = 16;
  localparam int BIN_IDX_OUT_W = 6;
  localparam int BINS_USED_W = 7;
  localparam logic [SIZE_W-1:0] CAP_RESET = 16'd1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;    // item accepted this cycle
    logic scan;    // walk the opened bins
    logic commit;  // place the item and load the result register
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic res_free;
  } status_t;

endpackage
`default_nettype wire

@@ sv/bfbp_ctrl.sv @@
// Controller state machine for the best-fit bin packer.
`default_nettype none
module bfbp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bfbp_pkg::status_t sts,
  output bfbp_pkg::cmd_t        cmd
);
  import bfbp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.res_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = sts.res_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/bfbp_dp.sv @@
// Datapath for the best-fit bin packer: bin memory, scan compare, result register.
`default_nettype none
module bfbp_dp #(
  parameter int MAX_BINS = bfbp_pkg::MAX_BINS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bfbp_pkg::cmd_t              cmd,
  output bfbp_pkg::status_t                sts,
  input  wire logic                        cfg_we,
  input  wire logic [bfbp_pkg::SIZE_W-1:0] cfg_wdata,
  input  wire logic [bfbp_pkg::SIZE_W-1:0] in_size,
  input  wire logic                        in_fresh,
  output logic [bfbp_pkg::BIN_IDX_OUT_W-1:0] res_bin_index,
  output logic                             res_opened,
  output logic [bfbp_pkg::BINS_USED_W-1:0] res_bins_used,
  output logic                             res_error,
  output logic                             res_valid,
  input  wire logic                        res_ready
);
  import bfbp_pkg::*;

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W = $clog2(MAX_BINS + 1);

  logic [SIZE_W-1:0] mem [MAX_BINS];
  logic [SIZE_W-1:0] rd_data_r;

  logic [SIZE_W-1:0] cap_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SIZE_W-1:0] size_r;
  logic              bad_r;
  logic [CNT_W-1:0]  issue_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              found_r;
  logic [SIZE_W-1:0] best_r;
  logic [IDX_W-1:0]  best_idx_r;

  logic              out_valid_r;
  logic [BIN_IDX_OUT_W-1:0] out_idx_r;
  logic              out_opened_r;
  logic [BINS_USED_W-1:0]   out_used_r;
  logic              out_err_r;

  logic              issue;
  logic              hit;
  logic              full;
  logic              err;
  logic              place_new;
  logic              we;
  logic [IDX_W-1:0]  wr_addr;
  logic [SIZE_W-1:0] wr_data;
  logic [31:0]       idx_wide;
  logic [31:0]       used_wide;

  assign issue = cmd.scan && !bad_r && (issue_r < count_r);
  assign hit   = rd_vld_r && (rd_data_r >= size_r) && (!found_r || rd_data_r < best_r);

  assign sts.scan_done = (bad_r || issue_r == count_r) && !rd_vld_r;
  assign sts.res_free  = !out_valid_r || res_ready;

  assign full      = (count_r == CNT_W'(MAX_BINS));
  assign err       = bad_r || (!found_r && full);
  assign place_new = !err && !found_r;
  assign we        = cmd.commit && !err;
  assign wr_addr   = found_r ? best_idx_r : count_r[IDX_W-1:0];
  assign wr_data   = found_r ? (best_r - size_r) : (cap_r - size_r);
  assign count_nxt = count_r + CNT_W'(place_new);
  assign idx_wide  = err ? 32'd0 : 32'(wr_addr);
  assign used_wide = 32'(count_nxt);

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (issue) rd_data_r <= mem[issue_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.load) begin
        size_r   <= in_size;
        bad_r    <= (in_size == '0) || (in_size > cap_r);
        if (in_fresh) count_r <= '0;
        issue_r  <= '0;
        rd_vld_r <= 1'b0;
        found_r  <= 1'b0;
      end else begin
        rd_vld_r <= issue;
        if (issue) begin
          rd_idx_r <= issue_r[IDX_W-1:0];
          issue_r  <= issue_r + 1'b1;
        end
        if (hit) begin
          found_r    <= 1'b1;
          best_r     <= rd_data_r;
          best_idx_r <= rd_idx_r;
        end
        if (cmd.commit) count_r <= count_nxt;
      end
      if (cmd.commit) begin
        out_valid_r  <= 1'b1;
        out_idx_r    <= idx_wide[BIN_IDX_OUT_W-1:0];
        out_opened_r <= place_new;
        out_used_r   <= used_wide[BINS_USED_W-1:0];
        out_err_r    <= err;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign res_valid     = out_valid_r;
  assign res_bin_index = out_idx_r;
  assign res_opened    = out_opened_r;
  assign res_bins_used = out_used_r;
  assign res_error     = out_err_r;

endmodule
`default_nettype wire

@@ sv/best_fit_bin_packer.sv @@
// Best-fit bin packer top level: streaming ports, controller and datapath.
// One item at a time: a new item is accepted only after the last result is loaded into
// the output register. The scan walks every open bin, at most MAX_BINS, one capacity per
// cycle, and reads nothing when no bin is open or the item is rejected on load (zero or
// oversize).
// Reset (rst_n low, synchronous): packing emptied, capacity back to 1000,
// output channel empty; the bin memory is not cleared.
`default_nettype none
module best_fit_bin_packer #(
  parameter int MAX_BINS = bfbp_pkg::MAX_BINS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,    // bin_capacity
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // [15:0] item_size
  input  wire logic        in_tuser,     // [0] start_new
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // [5:0] bin_index, [6] opened_bin,
                                         // [13:7] bins_used, [15:14] zero
  output logic             out_tuser     // [0] error
);
  import bfbp_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic [BIN_IDX_OUT_W-1:0] bin_index;
  logic                     opened;
  logic [BINS_USED_W-1:0]   bins_used;

  bfbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfbp_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_size       (in_tdata),
    .in_fresh      (in_tuser),
    .res_bin_index (bin_index),
    .res_opened    (opened),
    .res_bins_used (bins_used),
    .res_error     (out_tuser),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready)
  );

  assign out_tdata = {2'b00, bins_used, opened, bin_index};

endmodule
`default_nettype wire

@@ sv/bfbp_checker.sv @@
// Port-level assertions for the best-fit bin packer, bound to the top level.
`default_nettype none
module bfbp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a rejected item reports bin 0 and no new bin
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[6:0] == 7'd0)
    else $error("error result carries placement");

  // opening a bin means at least one bin is in use
  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[13:7] != 7'd0 && !out_tuser)
    else $error("opened bin with zero count");

  // the controller leaves idle on an accept, so no back-to-back accepts
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind best_fit_bin_packer bfbp_checker u_bfbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

@@ bench/best_fit_bin_packer_chk.sv @@
// Scoreboard for the best-fit bin packer: tracks bin state, predicts each placement, compares.
module best_fit_bin_packer_chk #(
  parameter int MAX_BINS = bfbp_pkg::MAX_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bfbp_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [15:0]                 in_tdata,
  input  logic                        in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [15:0]                 out_tdata,
  input  logic                        out_tuser,
  output int                          fail_count,
  output int                          pending,
  output int                          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import bfbp_pkg::*;

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [BIN_IDX_OUT_W-1:0] bin_idx;
    logic                     opened;
    logic [BINS_USED_W-1:0]   used;
    logic                     err;
  } placement_t;

  logic [SIZE_W-1:0] bin_cap;
  logic [SIZE_W-1:0] room [MAX_BINS];
  int                bins_open;
  int                errs;
  int                seen;
  placement_t        placements_due[$];

  // Best fit: tightest opened bin that still holds the item, lowest index on ties.
  function automatic placement_t place_item(input logic [SIZE_W-1:0] size, input logic fresh);
    placement_t        res;
    logic              found;
    logic [SIZE_W-1:0] best;
    int                slot;
    res   = '0;
    found = 1'b0;
    best  = '0;
    slot  = 0;
    if (fresh) bins_open = 0;
    if (size == '0 || size > bin_cap) begin
      res.err = 1'b1;
    end else begin
      for (int i = 0; i < bins_open; i++) begin
        if (room[i] >= size && (!found || room[i] < best)) begin
          found = 1'b1;
          best  = room[i];
          slot  = i;
        end
      end
      if (found) begin
        room[slot] = best - size;
      end else if (bins_open >= MAX_BINS) begin
        res.err = 1'b1;
        slot    = 0;
      end else begin
        slot       = bins_open;
        room[slot] = bin_cap - size;
        bins_open++;
        res.opened = 1'b1;
      end
    end
    res.bin_idx = res.err ? '0 : BIN_IDX_OUT_W'(slot);
    res.used    = BINS_USED_W'(bins_open);
    return res;
  endfunction

  task automatic flag(input string field, input int want, input int got);
    errs++;
    if (errs <= REPORT_CAP)
      $display("%0t: result %0d %s expected %0d, got %0d", $realtime, seen, field, want, got);
  endtask

  always @(posedge clk) begin
    placement_t want, got;
    if (!rst_n) begin
      bin_cap   = CAP_RESET;
      bins_open = 0;
      placements_due.delete();
    end else begin
      if (cfg_we) bin_cap = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got.bin_idx = out_tdata[5:0];
        got.opened  = out_tdata[6];
        got.used    = out_tdata[13:7];
        got.err     = out_tuser;
        seen++;
        if (placements_due.size() == 0) begin
          errs++;
          if (errs <= REPORT_CAP)
            $display("%0t: result %0d arrived with nothing expected, expected none, got %h/%b",
                     $realtime, seen, out_tdata, out_tuser);
        end else begin
          want = placements_due.pop_front();
          if (got.bin_idx !== want.bin_idx) flag("bin_index", want.bin_idx, got.bin_idx);
          if (got.opened !== want.opened) flag("opened_bin", want.opened, got.opened);
          if (got.used !== want.used) flag("bins_used", want.used, got.used);
          if (got.err !== want.err) flag("error", want.err, got.err);
        end
      end
      if (in_tvalid && in_tready)
        placements_due.insert(placements_due.size(), place_item(in_tdata, in_tuser));
    end
    fail_count   <= errs;
    pending      <= placements_due.size();
    result_count <= seen;
  end

endmodule

@@ bench/best_fit_bin_packer_tb.sv @@
// Top of the best-fit bin packer bench: clock, reset, stimulus, flow control and verdict.
module best_fit_bin_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfbp_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_OFF    = 300;
  localparam int TAIL_CYCLES = MAX_BINS_DEF + 16;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  int          fail_count;
  int          pending;
  int          result_count;

  int          snd_idle  = 13;
  int          rcv_idle  = 45;
  int          hold_req  = 0;
  int          items_sent = 0;
  int          stuck_cycles = 0;
  logic [15:0] cur_cap   = CAP_RESET;

  always begin
    #5 clk = 1'b0;
    #5 clk = 1'b1;
  end

  best_fit_bin_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  best_fit_bin_packer_chk chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  // Called at a rising edge; returns at the edge where the item is taken.
  // in_tvalid stays high afterwards so back-to-back items need no toggle.
  task automatic send_item(input logic [15:0] size, input logic fresh);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= size;
    in_tuser  <= fresh;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cap = value;
  endtask

  // Sizes lean toward legal values, with zero, oversize and tiny items mixed in.
  task automatic run_random(input int count, input int fresh_odds);
    logic [15:0] size;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (cur_cap == '0 || pick < 6)
        size = 16'($urandom_range(16'hFFFF));
      else if (pick < 10)
        size = '0;
      else if (pick < 16)
        size = (cur_cap == 16'hFFFF) ? cur_cap :
               16'($urandom_range(16'hFFFF, 32'(cur_cap) + 1));
      else if (pick < 35)
        size = 16'($urandom_range((cur_cap < 8) ? cur_cap : 8, 1));
      else if (pick < 50)
        size = 16'($urandom_range(cur_cap, 32'(cur_cap) / 2 + 1));
      else
        size = 16'($urandom_range(cur_cap, 1));
      send_item(size, $urandom_range(fresh_odds - 1) == 0);
    end
  endtask

  initial begin : rx_side
    int stall_len;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_len = hold_req;
        hold_req  = 0;
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      stuck_cycles++;
    else
      stuck_cycles = 0;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $realtime, STUCK_LIMIT);
      $display("[best_fit_bin_packer] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int saved_idle;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacity: zero size, oversize, exact fit, tightest of two fitting bins
    send_item(16'd0, 1'b1);
    send_item(16'd1001, 1'b0);
    send_item(16'd65535, 1'b0);
    send_item(16'd600, 1'b0);
    send_item(16'd700, 1'b0);
    send_item(16'd300, 1'b0);
    send_item(16'd1000, 1'b0);
    send_item(16'd400, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd500, 1'b1);
    send_item(16'd500, 1'b0);
    send_item(16'd200, 1'b0);
    send_item(16'd0, 1'b0);
    drain();

    // capacity shrinks mid-packing: open bins keep their room, oversize still rejected
    write_capacity(16'd100);
    send_item(16'd300, 1'b0);
    send_item(16'd100, 1'b0);
    send_item(16'd100, 1'b1);
    drain();

    write_capacity(16'hFFFF);
    send_item(16'hFFFF, 1'b1);
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'd1, 1'b0);
    run_random(150, 40);

    // output held off while input keeps coming: block fills and backs up
    hold_req   = HOLD_OFF;
    saved_idle = snd_idle;
    snd_idle   = 0;
    run_random(24, 40);
    snd_idle   = saved_idle;
    drain();

    // unit capacity: every legal item opens a bin until the store is full
    write_capacity(16'd1);
    run_random(120, 250);
    drain();

    snd_idle = 45;
    rcv_idle = 13;
    write_capacity(16'd0);
    run_random(10, 4);
    drain();
    write_capacity(16'd37);
    run_random(150, 300);
    drain();
    write_capacity(16'd1000);
    run_random(100, 30);
    drain();

    snd_idle = 0;
    rcv_idle = 0;
    write_capacity(16'd5000);
    run_random(130, 60);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items, checked %0d placements across capacities 0, 1, 37, 100,",
             items_sent, result_count);
    $display("1000, 5000 and 65535, with full bin stores, a long output stall and drains.");
    if (fail_count == 0 && pending == 0)
      $display("[best_fit_bin_packer] OK");
    else
      $display("[best_fit_bin_packer] ERROR");
    $finish;
  end

endmodule
